### src/sia_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sia_pkg
// Shared codes, field widths and types for the shifting insert/erase list.
// ----------------------------------------------------------------------------
package sia_pkg;

    localparam int CMD_BITS    = 3;
    localparam int POS_BITS    = 5;
    localparam int WORD_FIELD  = 32;
    localparam int IDX_BITS    = 5;
    localparam int STATUS_BITS = 2;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int WORD_BITS_DEFAULT = 32;

    localparam logic [CMD_BITS-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_ERASE  = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_FIND   = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd2;

    // shift controls broadcast to every cell of the chain
    typedef struct packed {
        logic do_append;
        logic do_insert;
        logic do_erase;
    } sia_shift_t;

endpackage
`default_nettype wire

### src/sia_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sia_cell
// One list entry: takes the new word, its left or right neighbor, or holds,
// and compares its entry against the searched value.
// ----------------------------------------------------------------------------
module sia_cell #(
    parameter int INDEX     = 0,
    parameter int WORD_BITS = 32,
    parameter int CMP_W     = 5
) (
    input  wire logic                  clk,
    input  wire sia_pkg::sia_shift_t   ctrl,
    input  wire logic [CMP_W-1:0]      pos,
    input  wire logic [CMP_W-1:0]      cnt,
    input  wire logic [WORD_BITS-1:0]  word,
    input  wire logic [WORD_BITS-1:0]  left_word,
    input  wire logic [WORD_BITS-1:0]  right_word,
    output logic      [WORD_BITS-1:0]  entry,
    output logic                       hit
);
    import sia_pkg::*;

    localparam logic [CMP_W-1:0] IDX      = CMP_W'(INDEX);
    localparam logic [CMP_W-1:0] IDX_NEXT = CMP_W'(INDEX + 1);

    logic [WORD_BITS-1:0] entry_reg;
    logic [WORD_BITS-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.do_insert)
        begin
            if (IDX == pos)
                entry_next = word;
            else if (IDX > pos && IDX <= cnt)
                entry_next = left_word;
        end
        else if (ctrl.do_append)
        begin
            if (IDX == cnt)
                entry_next = word;
        end
        else if (ctrl.do_erase)
        begin
            // the old last entry stays behind, it is beyond the new count
            if (IDX >= pos && IDX_NEXT < cnt)
                entry_next = right_word;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign hit   = (IDX < cnt) && (entry_reg == word);

endmodule
`default_nettype wire

### src/sia_first_hit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sia_first_hit
// Priority encoder: lowest index whose hit flag is set.
// ----------------------------------------------------------------------------
module sia_first_hit #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic [DEPTH-1:0] hits,
    output logic      [IDX_W-1:0] first,
    output logic                  any
);
    import sia_pkg::*;

    always_comb
    begin
        first = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (hits[i])
                first = IDX_W'(i);
        end
    end

    assign any = |hits;

endmodule
`default_nettype wire

### src/shifting_insert_erase_array.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shifting_insert_erase_array
// Ordered list of up to DEPTH words kept in a chain of shifting cells.
// ----------------------------------------------------------------------------
// One item is handled at a time and gives exactly one result. Accepting an
// item latches it; in the execute step every cell shifts or compares in
// parallel and the hit flags are registered; in the report step the first
// match is encoded and the output register is loaded. A new item is taken
// only after the sequencer returns to idle once the result is loaded, so no
// item is accepted before the last one is through; a stalled result holds
// the sequencer in its report step. Entries need no clearing after reset,
// only the count is cleared.
module shifting_insert_erase_array #(
    parameter int DEPTH     = sia_pkg::DEPTH_DEFAULT,
    parameter int WORD_BITS = sia_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [sia_pkg::CMD_BITS-1:0]   command,
    input  wire logic [sia_pkg::POS_BITS-1:0]   position,
    input  wire logic [sia_pkg::WORD_FIELD-1:0] data_word,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [sia_pkg::WORD_FIELD-1:0]      read_word,
    output logic [sia_pkg::IDX_BITS-1:0]        match_index,
    output logic                                found,
    output logic [sia_pkg::IDX_BITS-1:0]        entry_count,
    output logic [sia_pkg::STATUS_BITS-1:0]     status
);
    import sia_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    logic [CMD_BITS-1:0]    cmd_reg;
    logic [CMP_W-1:0]       pos_reg;
    logic [WORD_BITS-1:0]   word_reg;
    logic [CNT_W-1:0]       old_count_reg;
    logic [STATUS_BITS-1:0] st_reg, st_next;
    logic [WORD_BITS-1:0]   rd_reg, rd_next;
    logic [DEPTH-1:0]       hit_reg;

    logic [WORD_FIELD-1:0]  rd_out_reg;
    logic [IDX_BITS-1:0]    midx_out_reg;
    logic                   fnd_out_reg;
    logic [IDX_BITS-1:0]    cnt_out_reg;
    logic [STATUS_BITS-1:0] st_out_reg;

    logic [WORD_BITS-1:0] entry_bus [DEPTH];
    logic [DEPTH-1:0]     hit_bus;
    sia_shift_t           shift_ctrl;
    logic [CMP_W-1:0]     cnt_ext;
    logic                 full;
    logic                 in_accept;
    logic                 out_free;
    logic [IDX_W-1:0]     first_idx;
    logic                 any_hit;
    logic                 is_find;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cnt_ext   = CMP_W'(count_reg);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign is_find   = (cmd_reg == CMD_FIND);

    // execute step: decide what the chain does and what status to report
    always_comb
    begin
        shift_ctrl = '0;
        st_next    = ST_OK;
        rd_next    = '0;
        count_next = count_reg;
        if (state_reg == S_EXEC)
        begin
            case (cmd_reg)
                CMD_APPEND:
                begin
                    if (full)
                        st_next = ST_FULL;
                    else
                    begin
                        shift_ctrl.do_append = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_INSERT:
                begin
                    if (full)
                        st_next = ST_FULL;
                    else if (pos_reg > cnt_ext)
                        st_next = ST_RANGE;
                    else
                    begin
                        shift_ctrl.do_insert = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_ERASE:
                begin
                    if (pos_reg >= cnt_ext)
                        st_next = ST_RANGE;
                    else
                    begin
                        shift_ctrl.do_erase = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (pos_reg >= cnt_ext)
                        st_next = ST_RANGE;
                    else
                        rd_next = entry_bus[pos_reg[IDX_W-1:0]];
                end
                default:
                begin
                    st_next = ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg  <= command;
            pos_reg  <= CMP_W'(position);
            word_reg <= WORD_BITS'(data_word);
        end
        if (state_reg == S_EXEC)
        begin
            st_reg        <= st_next;
            rd_reg        <= rd_next;
            hit_reg       <= hit_bus;
            old_count_reg <= count_reg;
        end
        if (state_reg == S_DONE && out_free)
        begin
            rd_out_reg   <= WORD_FIELD'(rd_reg);
            fnd_out_reg  <= is_find && any_hit;
            cnt_out_reg  <= IDX_BITS'(count_reg);
            st_out_reg   <= st_reg;
            if (!is_find)
                midx_out_reg <= '0;
            else if (any_hit)
                midx_out_reg <= IDX_BITS'(first_idx);
            else
                midx_out_reg <= IDX_BITS'(old_count_reg);
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_w;
        logic [WORD_BITS-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = entry_bus[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = entry_bus[g+1];
        end

        sia_cell #(
            .INDEX     (g),
            .WORD_BITS (WORD_BITS),
            .CMP_W     (CMP_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (shift_ctrl),
            .pos        (pos_reg),
            .cnt        (cnt_ext),
            .word       (word_reg),
            .left_word  (left_w),
            .right_word (right_w),
            .entry      (entry_bus[g]),
            .hit        (hit_bus[g])
        );
    end

    sia_first_hit #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_first_hit (
        .hits  (hit_reg),
        .first (first_idx),
        .any   (any_hit)
    );

    assign out_valid   = out_valid_reg;
    assign read_word   = rd_out_reg;
    assign match_index = midx_out_reg;
    assign found       = fnd_out_reg;
    assign entry_count = cnt_out_reg;
    assign status      = st_out_reg;

endmodule
`default_nettype wire

### sim/shifting_insert_erase_array_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shifting_insert_erase_array_tb
// Self-checking bench for the shifting insert/erase list. Commands go in one
// item at a time and a local model of the list predicts each result, which is
// compared field by field with what comes out. Directed edge cases come first,
// then a full list, a long output hold-off and random traffic under several
// idle and stall patterns.
// ----------------------------------------------------------------------------
module shifting_insert_erase_array_tb;
    import sia_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEFAULT;
    localparam int HOLD_CYCLES = 60;
    localparam logic [CMD_BITS-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [WORD_FIELD-1:0]  read_word;
        logic [IDX_BITS-1:0]    match_index;
        logic                   found;
        logic [IDX_BITS-1:0]    entry_count;
        logic [STATUS_BITS-1:0] status;
    } list_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [CMD_BITS-1:0]    command;
    logic [POS_BITS-1:0]    position;
    logic [WORD_FIELD-1:0]  data_word;
    logic                   out_valid;
    logic                   out_stall;
    logic [WORD_FIELD-1:0]  read_word;
    logic [IDX_BITS-1:0]    match_index;
    logic                   found;
    logic [IDX_BITS-1:0]    entry_count;
    logic [STATUS_BITS-1:0] status;

    // local copy of the list
    logic [WORD_FIELD-1:0] list_words [LIST_DEPTH];
    int                    list_count;

    list_result_t pending_results [$];
    int fail_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int held_input_cycles;
    int cmd_tally [8];
    int full_flags;
    int range_flags;
    int find_hits;

    shifting_insert_erase_array #(
        .DEPTH     (LIST_DEPTH),
        .WORD_BITS (WORD_BITS_DEFAULT)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .position    (position),
        .data_word   (data_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_word   (read_word),
        .match_index (match_index),
        .found       (found),
        .entry_count (entry_count),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("timeout with %0d results still pending", pending_results.size());
        $display("** shifting_insert_erase_array: FAILED **");
        $finish;
    end

    // applies one command to the local list and returns the result it gives
    function automatic list_result_t apply_list_command(input logic [CMD_BITS-1:0] cmd,
                                                        input logic [POS_BITS-1:0] pos,
                                                        input logic [WORD_FIELD-1:0] word);
        list_result_t r;
        int i;
        bit hit;
        r = '0;
        hit = 1'b0;
        case (cmd)
            CMD_APPEND:
            begin
                if (list_count >= LIST_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    list_words[list_count] = word;
                    list_count++;
                end
            end
            CMD_INSERT:
            begin
                // a full list is flagged before the position is looked at
                if (list_count >= LIST_DEPTH)
                    r.status = ST_FULL;
                else if (pos > list_count)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = list_count; i > pos; i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = word;
                    list_count++;
                end
            end
            CMD_ERASE:
            begin
                if (pos >= list_count)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = pos; i + 1 < list_count; i++)
                        list_words[i] = list_words[i+1];
                    list_count--;
                end
            end
            CMD_READ:
            begin
                if (pos >= list_count)
                    r.status = ST_RANGE;
                else
                    r.read_word = list_words[pos];
            end
            CMD_FIND:
            begin
                r.match_index = IDX_BITS'(list_count);
                for (i = 0; i < list_count; i++)
                begin
                    if (!hit && list_words[i] == word)
                    begin
                        hit = 1'b1;
                        r.match_index = IDX_BITS'(i);
                    end
                end
                r.found = hit;
            end
            default: ;
        endcase
        r.entry_count = IDX_BITS'(list_count);
        return r;
    endfunction

    task automatic send_item(input logic [CMD_BITS-1:0] cmd,
                             input logic [POS_BITS-1:0] pos,
                             input logic [WORD_FIELD-1:0] word);
        list_result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        position  <= pos;
        data_word <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        r = apply_list_command(cmd, pos, word);
        pending_results.insert(pending_results.size(), r);
        cmd_tally[cmd]++;
        if (r.status == ST_FULL)
            full_flags++;
        if (r.status == ST_RANGE)
            range_flags++;
        if (r.found)
            find_hits++;
    endtask

    task automatic send_random_item(input int grow_pct);
        logic [CMD_BITS-1:0]   cmd;
        logic [POS_BITS-1:0]   pos;
        logic [WORD_FIELD-1:0] word;
        int pick;
        pick = $urandom_range(99);
        if (pick < 3)
            cmd = CMD_BITS'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
        else if (pick < 3 + grow_pct)
            cmd = ($urandom_range(1) != 0) ? CMD_APPEND : CMD_INSERT;
        else if (pick % 3 == 0)
            cmd = CMD_ERASE;
        else if (pick % 3 == 1)
            cmd = CMD_READ;
        else
            cmd = CMD_FIND;

        if ($urandom_range(99) < 15)
            pos = POS_BITS'($urandom_range(31));
        else if (cmd == CMD_INSERT)
            pos = POS_BITS'($urandom_range(list_count, 0));
        else
            pos = (list_count == 0) ? '0 : POS_BITS'($urandom_range(list_count - 1, 0));

        // small values and copies of stored words give duplicates and find hits
        pick = $urandom_range(99);
        if (list_count > 0 && (pick < 30 || (cmd == CMD_FIND && pick < 60)))
            word = list_words[$urandom_range(list_count - 1, 0)];
        else if (pick < 70)
            word = $urandom_range(7);
        else
            word = $urandom;
        send_item(cmd, pos, word);
    endtask

    task automatic wait_for_results;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_empty_list;
        send_item(CMD_READ, 0, 32'h0);
        send_item(CMD_ERASE, 0, 32'h0);
        send_item(CMD_FIND, 0, 32'h0);
        send_item(CMD_INSERT, 1, 32'h1);
        send_item(CMD_SPARE_FIRST, 5'd3, 32'hDEAD_BEEF);
        send_item(CMD_READ, 5'd31, 32'h0);
    endtask

    task automatic test_edit_ops;
        send_item(CMD_INSERT, 0, 32'hFFFF_FFFF);
        send_item(CMD_APPEND, 0, 32'h0);
        send_item(CMD_INSERT, 2, 32'hA5A5_5A5A);   // position equal to count
        send_item(CMD_INSERT, 1, 32'h1);
        send_item(CMD_FIND, 0, 32'h0);
        send_item(CMD_FIND, 0, 32'h1234_5678);
        send_item(CMD_READ, 0, 32'h0);
        send_item(CMD_READ, 3, 32'h0);
        send_item(CMD_READ, 4, 32'h0);
        send_item(CMD_ERASE, 1, 32'h0);
        send_item(CMD_ERASE, 3, 32'h0);
        send_item(CMD_ERASE, 2, 32'h0);
        send_item(CMD_INSERT, 5'd31, 32'h5555_5555);
        send_item(CMD_SPARE_LAST, 5'd31, 32'hFFFF_FFFF);
        send_item(CMD_READ, 5'd16, 32'h0);
    endtask

    task automatic test_full_list;
        logic [WORD_FIELD-1:0] last_word;
        last_word = '0;
        while (list_count < LIST_DEPTH)
        begin
            last_word = $urandom;
            send_item(CMD_APPEND, 0, last_word);
        end
        send_item(CMD_APPEND, 0, 32'h7);
        send_item(CMD_INSERT, 0, 32'h7);
        send_item(CMD_INSERT, 5'd20, 32'h7);
        send_item(CMD_FIND, 0, last_word);
        send_item(CMD_READ, POS_BITS'(LIST_DEPTH - 1), 32'h0);
        send_item(CMD_ERASE, POS_BITS'(LIST_DEPTH - 1), 32'h0);
        send_item(CMD_ERASE, 0, 32'h0);
        send_item(CMD_INSERT, POS_BITS'(LIST_DEPTH - 2), 32'hFFFF_FFFF);
    endtask

    task automatic test_output_hold_off;
        int n;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        for (n = 0; n < 12; n++)
            send_random_item(50);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int grow_pct, input int n_items);
        int n;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (n = 0; n < n_items; n++)
            send_random_item(grow_pct);
    endtask

    // output stall pattern, with a long hold-off on request
    initial
    begin : output_stall_driver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [WORD_FIELD-1:0] want,
                                        input logic [WORD_FIELD-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    initial
    begin : result_checker
        list_result_t want;
        forever
        begin
            @(posedge clk);
            if (in_valid && in_stall)
                held_input_cycles++;
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with none expected: expected nothing, got count %0d",
                             $time, entry_count);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("read_word", want.read_word, read_word);
                    check_field("match_index", want.match_index, match_index);
                    check_field("found", want.found, found);
                    check_field("entry_count", want.entry_count, entry_count);
                    check_field("status", want.status, status);
                end
            end
        end
    end

    initial
    begin
        int k;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        command           = CMD_APPEND;
        position          = '0;
        data_word         = '0;
        list_count        = 0;
        fail_count        = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_requests     = 0;
        held_input_cycles = 0;
        full_flags        = 0;
        range_flags       = 0;
        find_hits         = 0;
        for (k = 0; k < 8; k++)
            cmd_tally[k] = 0;
        for (k = 0; k < LIST_DEPTH; k++)
            list_words[k] = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_list;
        test_edit_ops;
        test_full_list;
        test_output_hold_off;
        test_random_traffic(0, 0, 60, 120);
        test_random_traffic(58, 0, 45, 120);
        test_random_traffic(0, 58, 55, 120);
        test_random_traffic(21, 21, 40, 120);
        test_random_traffic(0, 0, 35, 30);

        in_valid <= 1'b0;
        wait_for_results;
        repeat (8) @(posedge clk);

        $display("covered append %0d, insert %0d, erase %0d, read %0d, find %0d, spare %0d items",
                 cmd_tally[CMD_APPEND], cmd_tally[CMD_INSERT], cmd_tally[CMD_ERASE],
                 cmd_tally[CMD_READ], cmd_tally[CMD_FIND],
                 cmd_tally[5] + cmd_tally[6] + cmd_tally[7]);
        $display("full flags %0d, range flags %0d, find hits %0d, input held %0d cycles",
                 full_flags, range_flags, find_hits, held_input_cycles);
        if (fail_count == 0)
            $display("** shifting_insert_erase_array: PASSED **");
        else
            $display("** shifting_insert_erase_array: FAILED **");
        $finish;
    end

endmodule

### sim.f
src/sia_pkg.sv
src/sia_cell.sv
src/sia_first_hit.sv
src/shifting_insert_erase_array.sv
sim/shifting_insert_erase_array_tb.sv
